### rtl/f32ac_pkg.sv
package f32ac_pkg;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_ASIN = 3'd4,
    CMD_SQRT = 3'd5,
    CMD_LOG  = 3'd6,
    CMD_NONE = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    AN_NONE      = 3'd0,
    AN_PRECISION = 3'd1,
    AN_INFINITY  = 3'd2,
    AN_NAN       = 3'd3,
    AN_CANCEL    = 3'd4,
    AN_UNDERFLOW = 3'd5,
    AN_DIVZERO   = 3'd6
  } anomaly_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  localparam logic [9:0]  FACTOR_RESET = 10'd4;
  // 2^25 - 1: the overflow threshold is (2^25 - 1) * 2^103
  localparam logic [24:0] OVF_MANT     = 25'h1FF_FFFF;
  localparam logic [31:0] QNAN         = 32'h7FC0_0000;
  localparam logic [31:0] MAX_FINITE   = 32'h7F7F_FFFF;
  localparam logic [30:0] ONE_MAG      = 31'h3F80_0000;

  function automatic logic f_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic f_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic f_zero(input logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // significand with hidden bit
  function automatic logic [23:0] f_mant(input logic [31:0] x);
    return {x[30:23] != 8'd0, x[22:0]};
  endfunction

  // exponent with subnormals taken as exponent one
  function automatic logic [7:0] f_bexp(input logic [31:0] x);
    return (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
  endfunction

endpackage

### rtl/f32ac_addsub.sv
module f32ac_addsub (
  input  logic                  clk,
  input  f32ac_pkg::stage_en_t  en,
  input  logic [31:0]           a,
  input  logic [31:0]           b,
  input  logic                  sub,
  output logic [31:0]           res
);
  import f32ac_pkg::*;

  // stage 1: order operands by magnitude, catch specials
  logic [31:0] bb, x, y, spec_val_c;
  logic        swap, nan_in, ainf, binf, spec_c;

  logic        sx1, eff_sub1, spec1;
  logic [7:0]  ex1, dexp1;
  logic [23:0] mx1, my1;
  logic [31:0] spec_val1;

  always_comb begin
    bb     = {b[31] ^ sub, b[30:0]};
    swap   = b[30:0] > a[30:0];
    x      = swap ? bb : a;
    y      = swap ? a : bb;
    nan_in = f_nan(a) || f_nan(b);
    ainf   = f_inf(a);
    binf   = f_inf(bb);
    spec_c = nan_in || ainf || binf;
    if (nan_in || (ainf && binf && (a[31] != bb[31]))) begin
      spec_val_c = QNAN;
    end else if (ainf) begin
      spec_val_c = a;
    end else begin
      spec_val_c = bb;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      sx1       <= x[31];
      eff_sub1  <= a[31] ^ bb[31];
      ex1       <= f_bexp(x);
      dexp1     <= f_bexp(x) - f_bexp(y);
      mx1       <= f_mant(x);
      my1       <= f_mant(y);
      spec1     <= spec_c;
      spec_val1 <= spec_val_c;
    end
  end

  // stage 2: align smaller operand with guard, round and sticky bits, then add or subtract
  logic [26:0] ym, ysh, lost, yal, xm;
  logic [27:0] sum_c;

  logic [27:0] sum2;
  logic [7:0]  ex2;
  logic        sx2, spec2;
  logic [31:0] spec_val2;

  always_comb begin
    ym   = {my1, 3'b000};
    xm   = {mx1, 3'b000};
    ysh  = ym >> dexp1[4:0];
    lost = ym & ~({27{1'b1}} << dexp1[4:0]);
    if (dexp1 >= 8'd27) begin
      yal = {26'd0, my1 != 24'd0};
    end else begin
      yal = ysh | {26'd0, lost != 27'd0};
    end
    if (eff_sub1) begin
      sum_c = {1'b0, xm} - {1'b0, yal};
    end else begin
      sum_c = {1'b0, xm} + {1'b0, yal};
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      sum2      <= sum_c;
      ex2       <= ex1;
      sx2       <= sx1;
      spec2     <= spec1;
      spec_val2 <= spec_val1;
    end
  end

  // stage 3: normalise, round to nearest even, pack
  logic [4:0]  lz;
  logic [7:0]  lim, sh8;
  logic [26:0] m;
  logic [8:0]  e9, ef;
  logic [23:0] man, manf;
  logic        up;
  logic [24:0] mr;
  logic [31:0] res_c;

  always_comb begin
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (sum2[i]) lz = 5'(26 - i);
    end
    lim = ex2 - 8'd1;
    sh8 = ({3'b000, lz} > lim) ? lim : {3'b000, lz};
    if (sum2[27]) begin
      m  = {sum2[27:2], sum2[1] | sum2[0]};
      e9 = {1'b0, ex2} + 9'd1;
    end else begin
      m  = sum2[26:0] << sh8[4:0];
      e9 = {1'b0, ex2} - {1'b0, sh8};
    end
    man = m[26:3];
    up  = m[2] && ((m[1:0] != 2'b00) || man[0]);
    mr  = {1'b0, man} + {24'd0, up};
    if (mr[24]) begin
      manf = mr[24:1];
      ef   = e9 + 9'd1;
    end else begin
      manf = mr[23:0];
      ef   = e9;
    end
    if (spec2) begin
      res_c = spec_val2;
    end else if (sum2 == 28'd0) begin
      res_c = 32'd0;
    end else if (ef >= 9'd255) begin
      res_c = {sx2, 8'hFF, 23'd0};
    end else begin
      res_c = {sx2, manf[23] ? ef[7:0] : 8'd0, manf[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      res <= res_c;
    end
  end

endmodule

### rtl/f32ac_muldiv.sv
module f32ac_muldiv (
  input  logic                  clk,
  input  f32ac_pkg::stage_en_t  en,
  input  logic [31:0]           a,
  input  logic [31:0]           b,
  output logic                  mul_ovf,
  output logic                  mul_unf,
  output logic                  div_ovf,
  output logic                  div_unf
);
  import f32ac_pkg::*;

  // exact product / quotient compared against the rounding thresholds,
  // so no divider and no rounding is needed
  logic [23:0]        ma, mb;
  logic [7:0]         ea, eb;

  logic [47:0]        prod;
  logic [8:0]         esum;
  logic signed [10:0] ediff;
  logic [23:0]        ma1, mb1;
  logic [48:0]        mbt;

  assign ma = f_mant(a);
  assign mb = f_mant(b);
  assign ea = f_bexp(a);
  assign eb = f_bexp(b);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod  <= 48'(ma) * 48'(mb);
      esum  <= {1'b0, ea} + {1'b0, eb};
      ediff <= $signed({3'b000, ea}) - $signed({3'b000, eb});
      mbt   <= {mb, 25'd0} - {25'd0, mb};
      ma1   <= ma;
      mb1   <= mb;
    end
  end

  logic signed [10:0] k, j, d, e, nj, nd, ne;
  logic               mul_ovf_c, mul_unf_c, div_ovf_c, div_unf_c;
  logic               mul_ovf2, mul_unf2, div_ovf2, div_unf2;

  always_comb begin
    k  = 11'sd150 - $signed({2'b00, esum});
    j  = 11'sd403 - $signed({2'b00, esum});
    d  = ediff + 11'sd150;
    e  = ediff - 11'sd103;
    nj = -j;
    nd = -d;
    ne = -e;

    // product at or below half the smallest subnormal
    if (k >= 11'sd48) begin
      mul_unf_c = 1'b1;
    end else if (k < 11'sd0) begin
      mul_unf_c = 1'b0;
    end else begin
      mul_unf_c = prod <= (48'd1 << k[5:0]);
    end

    if (j >= 11'sd24) begin
      mul_ovf_c = 1'b0;
    end else if (j >= 11'sd0) begin
      mul_ovf_c = prod >= (48'(OVF_MANT) << j[4:0]);
    end else if (nj >= 11'sd25) begin
      mul_ovf_c = 1'b1;
    end else begin
      mul_ovf_c = (73'(prod) << nj[4:0]) >= 73'(OVF_MANT);
    end

    if (d >= 11'sd24) begin
      div_unf_c = 1'b0;
    end else if (d >= 11'sd0) begin
      div_unf_c = (48'(ma1) << d[4:0]) <= 48'(mb1);
    end else if (nd >= 11'sd24) begin
      div_unf_c = 1'b1;
    end else begin
      div_unf_c = 48'(ma1) <= (48'(mb1) << nd[4:0]);
    end

    if (e >= 11'sd49) begin
      div_ovf_c = 1'b1;
    end else if (e >= 11'sd0) begin
      div_ovf_c = (73'(ma1) << e[5:0]) >= 73'(mbt);
    end else if (ne >= 11'sd24) begin
      div_ovf_c = 1'b0;
    end else begin
      div_ovf_c = 73'(ma1) >= (73'(mbt) << ne[4:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      mul_ovf2 <= mul_ovf_c;
      mul_unf2 <= mul_unf_c;
      div_ovf2 <= div_ovf_c;
      div_unf2 <= div_unf_c;
    end
    if (en.s3) begin
      mul_ovf <= mul_ovf2;
      mul_unf <= mul_unf2;
      div_ovf <= div_ovf2;
      div_unf <= div_unf2;
    end
  end

endmodule

### rtl/f32ac_classify.sv
module f32ac_classify (
  input  f32ac_pkg::cmd_t      cmd,
  input  logic [31:0]          a,
  input  logic [31:0]          b,
  input  logic [31:0]          res,
  input  logic                 mul_ovf,
  input  logic                 mul_unf,
  input  logic                 div_ovf,
  input  logic                 div_unf,
  input  logic [9:0]           factor,
  output f32ac_pkg::anomaly_t  anomaly
);
  import f32ac_pkg::*;

  logic               za, zb, na, nb, ia, ib, fa, fb, nr, ir, zr;
  logic               adj, cancel;
  logic signed [10:0] s, ns;
  logic [23:0]        mr;

  always_comb begin
    za = f_zero(a);
    zb = f_zero(b);
    na = f_nan(a);
    nb = f_nan(b);
    ia = f_inf(a);
    ib = f_inf(b);
    fa = !na && !ia;
    fb = !nb && !ib;
    nr = f_nan(res);
    ir = f_inf(res);
    zr = f_zero(res);

    // ulp toward +inf of a negative power of two is half the usual one
    adj = a[31] && (a[22:0] == 23'd0) && (a[30:23] > 8'd1);
    s   = $signed({3'b000, f_bexp(res)}) - $signed({3'b000, f_bexp(a)})
          + (adj ? 11'sd1 : 11'sd0);
    ns  = -s;
    mr  = f_mant(res);
    if (a == MAX_FINITE) begin
      cancel = factor != 10'd0;
    end else if (s >= 11'sd10) begin
      cancel = 1'b0;
    end else if (s >= 11'sd0) begin
      cancel = (34'(mr) << s[3:0]) <= 34'(factor);
    end else if (ns >= 11'sd24) begin
      cancel = factor != 10'd0;
    end else begin
      cancel = 34'(mr) <= (34'(factor) << ns[4:0]);
    end

    anomaly = AN_NONE;
    case (cmd)
      CMD_ADD, CMD_SUB: begin
        if (za || zb) begin
          anomaly = AN_NONE;
        end else if (!nr && ((res == a) || (res == b))) begin
          anomaly = AN_PRECISION;
        end else if (ir && !ia && !ib) begin
          anomaly = AN_INFINITY;
        end else if (nr && !na && !nb) begin
          anomaly = AN_NAN;
        end else if (nr || ir || zr) begin
          anomaly = AN_NONE;
        end else if (cancel) begin
          anomaly = AN_CANCEL;
        end
      end
      CMD_MUL: begin
        if (fa && fb && mul_ovf) begin
          anomaly = AN_INFINITY;
        end else if ((za && ib) || (ia && zb)) begin
          anomaly = AN_NAN;
        end else if (fa && fb && !za && !zb && mul_unf) begin
          anomaly = AN_UNDERFLOW;
        end
      end
      CMD_DIV: begin
        if (zb) begin
          anomaly = AN_DIVZERO;
        end else if (fa && fb && !za && div_ovf) begin
          anomaly = AN_INFINITY;
        end else if (ia && ib) begin
          anomaly = AN_NAN;
        end else if (fa && !za && (ib || (fb && div_unf))) begin
          anomaly = AN_UNDERFLOW;
        end
      end
      CMD_ASIN: begin
        if (!na && (a[30:0] > ONE_MAG)) anomaly = AN_NAN;
      end
      CMD_SQRT: begin
        if (fa && a[31] && !za) anomaly = AN_NAN;
      end
      CMD_LOG: begin
        if (za) begin
          anomaly = AN_INFINITY;
        end else if (a[31] && !na) begin
          anomaly = AN_NAN;
        end
      end
      default: anomaly = AN_NONE;
    endcase
  end

endmodule

### rtl/float32_anomaly_checker.sv
// each transaction passes stage registers 1 to 3, then the output register to m_axis
// throughput: one transaction per cycle; each stage holds under back-pressure
// stage 3 carries the add/sub normalise and round, the longest stage
// reset clears all stage valid bits and sets ulp_factor to 4
module float32_anomaly_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // command[2:0], operand_a[34:3], operand_b[66:35]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // anomaly[2:0]
  input  logic        ulp_factor_we,
  input  logic [9:0]  ulp_factor_wdata
);
  import f32ac_pkg::*;

  logic [9:0]  ulp_factor;
  stage_en_t   en;
  logic        en4;
  logic        v1, v2, v3, v4;
  cmd_t        cmd_in, cmd1, cmd2, cmd3;
  logic [31:0] in_a, in_b, a1, a2, a3, b1, b2, b3;
  logic [31:0] res;
  logic        mul_ovf, mul_unf, div_ovf, div_unf;
  anomaly_t    anomaly_c, anomaly;

  assign cmd_in = cmd_t'(s_axis_tdata[2:0]);
  assign in_a   = s_axis_tdata[34:3];
  assign in_b   = s_axis_tdata[66:35];

  assign en4           = !v4 || m_axis_tready;
  assign en.s3         = !v3 || en4;
  assign en.s2         = !v2 || en.s3;
  assign en.s1         = !v1 || en.s2;
  assign s_axis_tready = en.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ulp_factor <= FACTOR_RESET;
    end else if (ulp_factor_we) begin
      ulp_factor <= ulp_factor_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en.s1) v1 <= s_axis_tvalid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (en4)   v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      cmd1 <= cmd_in;
      a1   <= in_a;
      b1   <= in_b;
    end
    if (en.s2) begin
      cmd2 <= cmd1;
      a2   <= a1;
      b2   <= b1;
    end
    if (en.s3) begin
      cmd3 <= cmd2;
      a3   <= a2;
      b3   <= b2;
    end
    if (en4) begin
      anomaly <= anomaly_c;
    end
  end

  f32ac_addsub u_addsub (
    .clk (clk),
    .en  (en),
    .a   (in_a),
    .b   (in_b),
    .sub (cmd_in == CMD_SUB),
    .res (res)
  );

  f32ac_muldiv u_muldiv (
    .clk     (clk),
    .en      (en),
    .a       (in_a),
    .b       (in_b),
    .mul_ovf (mul_ovf),
    .mul_unf (mul_unf),
    .div_ovf (div_ovf),
    .div_unf (div_unf)
  );

  f32ac_classify u_classify (
    .cmd     (cmd3),
    .a       (a3),
    .b       (b3),
    .res     (res),
    .mul_ovf (mul_ovf),
    .mul_unf (mul_unf),
    .div_ovf (div_ovf),
    .div_unf (div_unf),
    .factor  (ulp_factor),
    .anomaly (anomaly_c)
  );

  assign m_axis_tvalid = v4;
  assign m_axis_tdata  = {5'd0, anomaly};

  // a no-op transaction always reports none
  a_none_cmd: assert property (@(posedge clk) disable iff (rst)
    (v3 && en4 && (cmd3 == CMD_NONE)) |=> (anomaly == AN_NONE))
    else $error("no-op command gave an anomaly");

  // asin and sqrt domain checks only ever report NaN
  a_unary: assert property (@(posedge clk) disable iff (rst)
    (v3 && en4 && ((cmd3 == CMD_ASIN) || (cmd3 == CMD_SQRT)))
    |=> ((anomaly == AN_NONE) || (anomaly == AN_NAN)))
    else $error("asin/sqrt gave an unexpected anomaly");

  // a stalled stage 2 keeps its transaction
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !en.s2) |=> (v2 && $stable(a2) && $stable(cmd2)))
    else $error("stage 2 lost its transaction under stall");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd7))
    else $error("undefined anomaly code");

endmodule

### verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import f32ac_pkg::*;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] a;
    logic [31:0] b;
  } fop_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        ulp_factor_we = 1'b0;
  logic [9:0]  ulp_factor_wdata = '0;

  fop_t        pending_ops[$];
  anomaly_t    expected_anomalies[$];
  fop_t        cur_op;
  logic [9:0]  factor_shadow = FACTOR_RESET;
  bit          sent = 1'b0;
  bit          no_idle = 1'b0;
  bit          failed = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;
  int          quiet_cycles = 0;

  float32_anomaly_checker u_dut (
    .clk              (clk),
    .rst              (rst),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .ulp_factor_we    (ulp_factor_we),
    .ulp_factor_wdata (ulp_factor_wdata)
  );

  always #1 clk = ~clk;

  function automatic bit is_nan32(logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 0;
  endfunction

  function automatic bit is_inf32(logic [31:0] x);
    return x[30:0] == 31'h7F80_0000;
  endfunction

  function automatic bit is_zero32(logic [31:0] x);
    return x[30:0] == 0;
  endfunction

  function automatic bit feq(logic [31:0] x, logic [31:0] y);
    if (is_nan32(x) || is_nan32(y)) return 1'b0;
    return (is_zero32(x) && is_zero32(y)) || x == y;
  endfunction

  // value is (-1)^s * m * 2^e, rounded to nearest even
  function automatic logic [31:0] round_to_f32(logic s, logic [127:0] m, int e);
    int          p;
    int          sh;
    int          l;
    logic [127:0] q;
    bit          rb;
    bit          st;
    if (m == 0) return {s, 31'd0};
    p = 127;
    while (!m[p]) p--;
    sh = p - 23;
    if (sh < -149 - e) sh = -149 - e;
    l = e + sh;
    if (sh > 128) return {s, 31'd0};
    if (sh <= 0) begin
      q = m << (-sh);
    end else begin
      q = m >> sh;
      rb = m[sh-1];
      st = (m & ((128'd1 << (sh - 1)) - 1)) != 0;
      if (rb && (st || q[0])) q++;
    end
    if (q == 128'd1 << 24) begin
      q = q >> 1;
      l++;
    end
    if (q >= 128'd1 << 23) begin
      if (l + 150 >= 255) return {s, 31'h7F80_0000};
      return {s, 8'(l + 150), q[22:0]};
    end
    return {s, 8'd0, q[22:0]};
  endfunction

  function automatic logic [127:0] sig_of(logic [31:0] x);
    return {104'd0, x[30:23] != 0, x[22:0]};
  endfunction

  function automatic int exp_of(logic [31:0] x);
    return ((x[30:23] == 0) ? 1 : int'(x[30:23])) - 150;
  endfunction

  function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
    int           ea;
    int           eb;
    int           e0;
    logic [127:0] xa;
    logic [127:0] xb;
    if (is_nan32(a) || is_nan32(b)) return QNAN;
    if (is_inf32(a) && is_inf32(b)) return (a[31] != b[31]) ? QNAN : a;
    if (is_inf32(a)) return a;
    if (is_inf32(b)) return b;
    if (is_zero32(a) && is_zero32(b)) return {a[31] & b[31], 31'd0};
    if (is_zero32(a)) return b;
    if (is_zero32(b)) return a;
    ea = exp_of(a);
    eb = exp_of(b);
    e0 = (ea < eb) ? ea : eb;
    if (((ea > eb) ? ea : eb) - e0 > 62) e0 = ((ea > eb) ? ea : eb) - 62;
    // an operand far below the other only acts as a sticky bit
    xa = (ea >= e0) ? sig_of(a) << (ea - e0) : 128'd1;
    xb = (eb >= e0) ? sig_of(b) << (eb - e0) : 128'd1;
    if (a[31] == b[31]) return round_to_f32(a[31], xa + xb, e0);
    if (xa == xb) return 32'd0;
    if (xa > xb) return round_to_f32(a[31], xa - xb, e0);
    return round_to_f32(b[31], xb - xa, e0);
  endfunction

  function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
    logic s;
    s = a[31] ^ b[31];
    if (is_nan32(a) || is_nan32(b)) return QNAN;
    if (is_inf32(a) || is_inf32(b)) begin
      if (is_zero32(a) || is_zero32(b)) return QNAN;
      return {s, 31'h7F80_0000};
    end
    if (is_zero32(a) || is_zero32(b)) return {s, 31'd0};
    return round_to_f32(s, sig_of(a) * sig_of(b), exp_of(a) + exp_of(b));
  endfunction

  function automatic logic [31:0] f32_div(logic [31:0] a, logic [31:0] b);
    logic         s;
    logic [127:0] num;
    logic [127:0] quo;
    s = a[31] ^ b[31];
    if (is_nan32(a) || is_nan32(b)) return QNAN;
    if (is_inf32(a)) return is_inf32(b) ? QNAN : {s, 31'h7F80_0000};
    if (is_inf32(b)) return {s, 31'd0};
    if (is_zero32(b)) return is_zero32(a) ? QNAN : {s, 31'h7F80_0000};
    if (is_zero32(a)) return {s, 31'd0};
    num = sig_of(a) << 60;
    quo = num / sig_of(b);
    return round_to_f32(s, (quo << 1) | 128'(num % sig_of(b) != 0),
                        exp_of(a) - exp_of(b) - 61);
  endfunction

  // precision loss compares the result with the operands as given
  function automatic anomaly_t addsub_anomaly(logic [31:0] a, logic [31:0] b, bit sub);
    logic [31:0] res;
    logic [31:0] nxt;
    logic [31:0] ulp;
    logic [31:0] lim;
    if (is_zero32(a) || is_zero32(b)) return AN_NONE;
    res = f32_add(a, sub ? {~b[31], b[30:0]} : b);
    if (feq(res, a) || feq(res, b)) return AN_PRECISION;
    if (is_inf32(res) && !is_inf32(a) && !is_inf32(b)) return AN_INFINITY;
    if (is_nan32(res) && !is_nan32(a) && !is_nan32(b)) return AN_NAN;
    if (is_nan32(res) || is_inf32(res) || is_zero32(res)) return AN_NONE;
    // ulp of a, measured toward +infinity
    nxt = a[31] ? a - 1 : a + 1;
    ulp = f32_add(nxt, {~a[31], a[30:0]});
    ulp[31] = 1'b0;
    lim = f32_mul(round_to_f32(1'b0, 128'(factor_shadow), 0), ulp);
    if (!is_nan32(lim) && res[30:0] <= lim[30:0]) return AN_CANCEL;
    return AN_NONE;
  endfunction

  function automatic anomaly_t predict_anomaly(fop_t op);
    logic [31:0] res;
    bit          neg;
    neg = !is_nan32(op.a) && op.a[31] && !is_zero32(op.a);
    case (op.cmd)
      CMD_ADD: return addsub_anomaly(op.a, op.b, 1'b0);
      CMD_SUB: return addsub_anomaly(op.a, op.b, 1'b1);
      CMD_MUL, CMD_DIV: begin
        if (op.cmd == CMD_DIV && is_zero32(op.b)) return AN_DIVZERO;
        res = (op.cmd == CMD_DIV) ? f32_div(op.a, op.b) : f32_mul(op.a, op.b);
        if (is_inf32(res) && !is_inf32(op.a) && !is_inf32(op.b)) return AN_INFINITY;
        if (is_nan32(res) && !is_nan32(op.a) && !is_nan32(op.b)) return AN_NAN;
        if (!is_zero32(op.a) && !is_zero32(op.b) && is_zero32(res)) return AN_UNDERFLOW;
        return AN_NONE;
      end
      CMD_ASIN: return (!is_nan32(op.a) && op.a[30:0] > ONE_MAG) ? AN_NAN : AN_NONE;
      CMD_SQRT: return (neg && !is_inf32(op.a)) ? AN_NAN : AN_NONE;
      CMD_LOG: begin
        if (is_zero32(op.a)) return AN_INFINITY;
        return neg ? AN_NAN : AN_NONE;
      end
      default: return AN_NONE;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] rand_f32();
    logic [31:0] x;
    x = $urandom;
    case ($urandom_range(0, 11))
      0: x[30:0] = '0;
      1: x[30:0] = 31'h7F80_0000;
      2: x[30:23] = 8'hFF;
      3: x[30:23] = 8'h00;
      4: x[30:0] = MAX_FINITE[30:0];
      5: x[30:23] = 8'd126 + 8'($urandom_range(0, 2));
      6: x[30:23] = 8'($urandom_range(0, 24));
      7: x[30:23] = 8'($urandom_range(230, 254));
      default: ;
    endcase
    if (x[30:23] == 8'hFF && $urandom_range(0, 1) == 1) x[22:0] = 23'h40_0000;
    return x;
  endfunction

  function automatic fop_t rand_op();
    fop_t op;
    op.cmd = cmd_t'($urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0) op.cmd = cmd_t'($urandom_range(0, 1));
    op.a = rand_f32();
    op.b = rand_f32();
    case ($urandom_range(0, 5))
      // near cancellation: b sits a few ulps from a, sign at random
      0, 1: op.b = (op.a + 32'($urandom_range(0, 8)) - 32'd4) ^ {$urandom_range(0, 1) == 1, 31'd0};
      // far apart exponents: b's exponent is set 20 to 30 below a's, so most or all of b is lost
      2: op.b = {op.b[31], 8'(op.a[30:23] - 8'($urandom_range(20, 30))), op.b[22:0]};
      default: ;
    endcase
    return op;
  endfunction

  function automatic fop_t mk(cmd_t c, logic [31:0] a, logic [31:0] b);
    fop_t op;
    op.cmd = c;
    op.a = a;
    op.b = b;
    return op;
  endfunction

  task automatic wait_idle();
    while (pending_ops.size() != 0 || expected_anomalies.size() != 0 || s_axis_tvalid)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_factor(logic [9:0] v);
    @(negedge clk);
    ulp_factor_we = 1'b1;
    ulp_factor_wdata = v;
    factor_shadow = v;
    @(negedge clk);
    ulp_factor_we = 1'b0;
  endtask

  // input side
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_anomalies.push_back(predict_anomaly(cur_op));
      sent = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (sent || !s_axis_tvalid)) begin
      sent = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        cur_op = pending_ops.pop_front();
        s_axis_tdata <= {5'd0, cur_op.b, cur_op.a, cur_op.cmd};
        s_axis_tvalid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side
  always @(negedge clk) begin
    if (!rst) begin
      if (out_stall > 0) begin
        out_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        out_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_anomalies.size() == 0) begin
        $error("anomaly: unexpected transaction, actual %0d", m_axis_tdata[2:0]);
        failed = 1'b1;
      end else begin
        anomaly_t want;
        want = expected_anomalies.pop_front();
        if (m_axis_tdata[2:0] !== want) begin
          $error("anomaly: expected %0d, actual %0d", want, m_axis_tdata[2:0]);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [9:0] factors[6];
    factors = '{FACTOR_RESET, 10'd0, 10'd1023, 10'd1, 10'($urandom_range(2, 1022)), 10'd4};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    pending_ops.push_back(mk(CMD_ADD, 32'h3F80_0000, 32'hBF80_0000));
    pending_ops.push_back(mk(CMD_ADD, 32'h8000_0000, 32'h3F80_0000));
    pending_ops.push_back(mk(CMD_SUB, 32'h3F80_0000, 32'h0000_0000));
    pending_ops.push_back(mk(CMD_ADD, 32'h3F80_0000, 32'h3080_0000));
    pending_ops.push_back(mk(CMD_ADD, MAX_FINITE, MAX_FINITE));
    pending_ops.push_back(mk(CMD_ADD, 32'h7F80_0000, 32'hFF80_0000));
    pending_ops.push_back(mk(CMD_SUB, 32'h3F80_0001, 32'h3F80_0000));
    pending_ops.push_back(mk(CMD_ADD, MAX_FINITE, 32'hFF7F_FFFE));
    pending_ops.push_back(mk(CMD_ADD, 32'h7FC0_0000, 32'h3F80_0000));
    pending_ops.push_back(mk(CMD_SUB, 32'h4000_0000, 32'h3F80_0000));
    pending_ops.push_back(mk(CMD_SUB, 32'h3380_0000, 32'h3F80_0000));
    pending_ops.push_back(mk(CMD_MUL, MAX_FINITE, 32'h4000_0000));
    pending_ops.push_back(mk(CMD_MUL, 32'h0000_0001, 32'h0000_0001));
    pending_ops.push_back(mk(CMD_MUL, 32'h0000_0000, 32'hFF80_0000));
    pending_ops.push_back(mk(CMD_DIV, 32'h3F80_0000, 32'h8000_0000));
    pending_ops.push_back(mk(CMD_DIV, 32'h7FC0_0000, 32'h0000_0000));
    pending_ops.push_back(mk(CMD_DIV, 32'h7F80_0000, 32'hFF80_0000));
    pending_ops.push_back(mk(CMD_DIV, 32'h0080_0000, MAX_FINITE));
    pending_ops.push_back(mk(CMD_ASIN, 32'hBF80_0001, 32'h0));
    pending_ops.push_back(mk(CMD_ASIN, 32'hFF80_0000, 32'h0));
    pending_ops.push_back(mk(CMD_ASIN, 32'h7FC0_0000, 32'hFFFF_FFFF));
    pending_ops.push_back(mk(CMD_SQRT, 32'hBF80_0000, 32'h0));
    pending_ops.push_back(mk(CMD_SQRT, 32'h8000_0000, 32'h0));
    pending_ops.push_back(mk(CMD_SQRT, 32'hFF80_0000, 32'h0));
    pending_ops.push_back(mk(CMD_LOG, 32'h8000_0000, 32'h0));
    pending_ops.push_back(mk(CMD_LOG, 32'hBF80_0000, 32'h0));
    pending_ops.push_back(mk(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

    foreach (factors[i]) begin
      if (i != 0) set_factor(factors[i]);
      no_idle = (i == 3);
      repeat (155) pending_ops.push_back(rand_op());
      wait_idle();
    end

    if (failed)
      $display("simulation failed");
    else
      $display("simulation ok");
    $finish;
  end

endmodule

### filelist.f
rtl/f32ac_pkg.sv
rtl/f32ac_addsub.sv
rtl/f32ac_muldiv.sv
rtl/f32ac_classify.sv
rtl/float32_anomaly_checker.sv
verif/testbench.sv
